// ===== hw/rtl/imf_pkg.sv =====
`timescale 1ns / 1ps

package imf_pkg;

    // Lattice geometry and draw resolution
    localparam int ROWS      = 256;
    localparam int COLS      = 256;
    localparam int DRAW_BITS = 16;

    // Fixed field widths
    localparam int SITE_W     = 16;
    localparam int DRAW_W     = 16;
    localparam int LEVEL_W    = 17;
    localparam int TOTAL_W    = 18;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;

    // Derived lattice sizes
    localparam int CELL_COUNT = ROWS * COLS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int WORD_W     = 32;
    localparam int BIT_W      = 5;
    localparam int WORD_COUNT = (CELL_COUNT + WORD_W - 1) / WORD_W;
    localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    // Site field can exceed the lattice and must then be reduced
    localparam bit NEED_MOD = (CELL_COUNT < (1 << SITE_W));

    // Spin total after reset and per-flip step
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(CELL_COUNT);
    localparam logic [TOTAL_W-1:0] TOTAL_STEP  = 18'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT = 1'd1;

    typedef enum logic {
        OP_TRIAL = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    // Which lattice address the address unit produces
    typedef enum logic [2:0] {
        NB_SITE  = 3'd0,
        NB_LEFT  = 3'd1,
        NB_RIGHT = 3'd2,
        NB_UP    = 3'd3,
        NB_DOWN  = 3'd4
    } t_nb_sel;

    typedef struct packed {
        logic [ADDR_W:0] x;
        t_nb_sel         sel;
    } t_au_req;

endpackage

// ===== hw/rtl/imf_ram.sv =====
`timescale 1ns / 1ps

module imf_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/imf_addr_unit.sv =====
`timescale 1ns / 1ps

module imf_addr_unit (
    input  imf_pkg::t_au_req          i_req,
    output logic [imf_pkg::ADDR_W-1:0] o_addr
);
    import imf_pkg::*;

    localparam logic [ADDR_W:0] CELL_N    = (ADDR_W + 1)'(CELL_COUNT);
    localparam logic [ADDR_W:0] OFF_LEFT  = (ADDR_W + 1)'(CELL_COUNT - 1);
    localparam logic [ADDR_W:0] OFF_RIGHT = (ADDR_W + 1)'(1);
    localparam logic [ADDR_W:0] OFF_UP    = (ADDR_W + 1)'(CELL_COUNT - COLS);
    localparam logic [ADDR_W:0] OFF_DOWN  = (ADDR_W + 1)'(COLS);

    logic [ADDR_W:0] w_off;
    logic [ADDR_W:0] w_sum;

    // Offset of the requested neighbor; minus steps are added as N minus step
    always_comb begin
        unique case (i_req.sel)
            NB_SITE:  w_off = '0;
            NB_LEFT:  w_off = OFF_LEFT;
            NB_RIGHT: w_off = OFF_RIGHT;
            NB_UP:    w_off = OFF_UP;
            NB_DOWN:  w_off = OFF_DOWN;
            default:  w_off = '0;
        endcase
    end

    // Shared add, compare and conditional subtract; input stays below 2N
    assign w_sum  = i_req.x + w_off;
    assign o_addr = (w_sum >= CELL_N) ? ADDR_W'(w_sum - CELL_N) : ADDR_W'(w_sum);

endmodule

// ===== hw/rtl/ising_metropolis_flip.sv =====
`timescale 1ns / 1ps

// Metropolis spin-flip engine for a 2D Ising lattice with helical boundary.
// Input stream: tuser is the opcode (trial or read), tdata carries the site
// in bits 15:0 and the uniform draw in bits 31:16. Every input item gives
// exactly one output item: spin after the step in tdata bit 0, the running
// spin total (18-bit two's complement) in tdata bits 18:1, and tuser set
// when the trial flip was taken.
// The lattice lives in a one-port-read, one-port-write RAM of 32-bit words;
// one address unit (add, compare, subtract) forms every address in turn.
// A new item is accepted only in the idle state, after the last one is decided: a trial
// item passes five serial RAM reads, the drain state and the decision state; a read
// item makes one RAM read instead of five. When the lattice holds fewer than 65536
// sites the site is first reduced modulo the lattice size, one bit per cycle.
// The result sits in an output register; while the receiver stalls the
// block finishes the next item up to the decision cycle and waits there.
// After reset the RAM is filled with all-up spins, one word per cycle
// (2048 words at 256 x 256), and tready stays low meanwhile.
// Write the threshold registers over the cfg port only while no item is in flight.
module ising_metropolis_flip (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [imf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [imf_pkg::LEVEL_W-1:0]       i_cfg_data,
    // Input item stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [imf_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,  // site, random_draw
    input  logic                              i_s_axis_tuser,  // opcode
    // Result item stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [imf_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,  // spin_value, spin_total
    output logic                              o_m_axis_tuser   // flip_taken
);
    import imf_pkg::*;

    localparam logic [4:0] MOD_LAST = 5'(SITE_W - 1);
    localparam logic [4:0] RD_LAST  = 5'd4;
    localparam int         CMP_W    = DRAW_BITS + LEVEL_W;
    localparam int         FRAC_W   = LEVEL_W - 1;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_MOD,
        S_RD,
        S_LAST,
        S_EVAL
    } t_state;

    t_state                r_state;
    logic [4:0]            r_cnt;
    logic [ADDR_W-1:0]     r_site;
    logic [SITE_W-1:0]     r_site_sh;
    logic [DRAW_W-1:0]     r_draw;
    t_op                   r_op;
    logic [WORD_W-1:0]     r_site_word;
    logic                  r_s;
    logic [3:0]            r_nb;
    logic                  r_cap_vld;
    logic [2:0]            r_cap_sel;
    logic [BIT_W-1:0]      r_cap_bit;
    logic [WORD_AW-1:0]    r_init_addr;
    logic [TOTAL_W-1:0]    r_total;
    logic [LEVEL_W-1:0]    r_level4;
    logic [LEVEL_W-1:0]    r_level8;
    logic                  r_out_vld;
    logic                  r_out_spin;
    logic                  r_out_taken;

    t_au_req               w_au_req;
    logic [ADDR_W-1:0]     w_au_addr;
    logic                  w_ram_we;
    logic [WORD_AW-1:0]    w_ram_waddr;
    logic [WORD_W-1:0]     w_ram_wdata;
    logic [WORD_AW-1:0]    w_ram_raddr;
    logic [WORD_W-1:0]     w_ram_rdata;
    logic                  w_emit;
    logic [2:0]            w_ones;
    logic [2:0]            w_agree;
    logic [LEVEL_W-1:0]    w_level;
    logic [DRAW_BITS-1:0]  w_d;
    logic [CMP_W-1:0]      w_lhs;
    logic [CMP_W-1:0]      w_rhs;
    logic                  w_below;
    logic                  w_taken;

    // Shared address unit request: modulo step or neighbor address
    always_comb begin
        if (r_state == S_MOD) begin
            w_au_req.x   = {r_site, r_site_sh[SITE_W-1]};
            w_au_req.sel = NB_SITE;
        end else begin
            w_au_req.x = {1'b0, r_site};
            unique case (r_cnt)
                5'd0:    w_au_req.sel = NB_SITE;
                5'd1:    w_au_req.sel = NB_LEFT;
                5'd2:    w_au_req.sel = NB_RIGHT;
                5'd3:    w_au_req.sel = NB_UP;
                default: w_au_req.sel = NB_DOWN;
            endcase
        end
    end

    imf_addr_unit u_addr (
        .i_req  (w_au_req),
        .o_addr (w_au_addr)
    );

    // Energy change class from agreeing neighbors; dE is 8 at four, 4 at three
    assign w_ones  = 3'($countones(r_nb));
    assign w_agree = r_s ? w_ones : 3'(3'd4 - w_ones);
    assign w_level = (w_agree == 3'd3) ? r_level4 : r_level8;
    assign w_d     = DRAW_BITS'(r_draw);
    assign w_lhs   = CMP_W'(w_d) << FRAC_W;
    assign w_rhs   = CMP_W'(w_level) << DRAW_BITS;
    assign w_below = (w_lhs < w_rhs);
    assign w_taken = (r_op == OP_TRIAL) && ((w_agree <= 3'd2) || w_below);

    assign w_emit = !r_out_vld || i_m_axis_tready;

    // Lattice RAM ports
    assign w_ram_we    = (r_state == S_INIT) || ((r_state == S_EVAL) && w_emit && w_taken);
    assign w_ram_waddr = (r_state == S_INIT) ? r_init_addr : WORD_AW'(r_site >> BIT_W);
    assign w_ram_wdata = (r_state == S_INIT) ? '1
                       : (r_site_word ^ (WORD_W'(1) << BIT_W'(r_site)));
    assign w_ram_raddr = WORD_AW'(w_au_addr >> BIT_W);

    imf_ram #(
        .DEPTH (WORD_COUNT),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level4 <= '0;
            r_level8 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FOUR:  r_level4 <= i_cfg_data;
                CFG_EIGHT: r_level8 <= i_cfg_data;
            endcase
        end
    end

    // Capture read data in the cycle after each issued address
    always_ff @(posedge i_clk) begin
        if (r_cap_vld) begin
            if (r_cap_sel == 3'd0) begin
                r_site_word <= w_ram_rdata;
                r_s         <= w_ram_rdata[r_cap_bit];
            end else begin
                r_nb[2'(r_cap_sel - 3'd1)] <= w_ram_rdata[r_cap_bit];
            end
        end
    end

    // Sequencer, spin total and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_init_addr <= '0;
            r_cap_vld   <= 1'b0;
            r_total     <= TOTAL_RESET;
            r_out_vld   <= 1'b0;
        end else begin
            r_cap_vld <= 1'b0;
            // Result leaves; in the decision state the register is refilled below
            if (r_out_vld && i_m_axis_tready && (r_state != S_EVAL)) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    if (r_init_addr == WORD_AW'(WORD_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_init_addr <= r_init_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_op      <= t_op'(i_s_axis_tuser);
                        r_site_sh <= i_s_axis_tdata[SITE_W-1:0];
                        r_draw    <= i_s_axis_tdata[SITE_W +: DRAW_W];
                        r_site    <= NEED_MOD ? '0 : ADDR_W'(i_s_axis_tdata[SITE_W-1:0]);
                        r_cnt     <= '0;
                        r_state   <= NEED_MOD ? S_MOD : S_RD;
                    end
                end
                S_MOD: begin
                    // Restoring remainder, one site bit per cycle
                    r_site    <= w_au_addr;
                    r_site_sh <= r_site_sh << 1;
                    if (r_cnt == MOD_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_RD: begin
                    r_cap_vld <= 1'b1;
                    r_cap_sel <= r_cnt[2:0];
                    r_cap_bit <= BIT_W'(w_au_addr);
                    if ((r_op == OP_READ) || (r_cnt == RD_LAST)) begin
                        r_state <= S_LAST;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_LAST: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (w_emit) begin
                        r_out_vld   <= 1'b1;
                        r_out_taken <= w_taken;
                        r_out_spin  <= w_taken ? !r_s : r_s;
                        if (w_taken) begin
                            r_total <= r_s ? (r_total - TOTAL_STEP) : (r_total + TOTAL_STEP);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {5'b0, r_total, r_out_spin};
    assign o_m_axis_tuser  = r_out_taken;

    // A taken flip always moves the total
    a_flip_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && w_emit && w_taken) |=> (r_total != $past(r_total)))
        else $error("taken flip left spin total unchanged");

    // A read item never reports a flip
    a_read_no_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && w_emit && r_op == OP_READ) |=> (o_m_axis_tvalid && !r_out_taken))
        else $error("read item reported a flip");

    // RAM is written only by the fill pass or a taken flip
    a_ram_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == S_INIT || r_state == S_EVAL))
        else $error("lattice write outside fill or decision");

    // Read data is captured only while the read phase drains
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap_vld |-> (r_state == S_RD || r_state == S_LAST))
        else $error("read capture outside read phase");

endmodule
